// ===== hdl/m3inv_pkg.sv =====
package m3inv_pkg;

    // Default element format: signed Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Singularity threshold register
    localparam int                  EPS_WIDTH = 31;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(66);

endpackage

// ===== hdl/matrix3_inverse.sv =====
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+------------------------------------------
// input    | i_in_valid / o_in_ready     | i_a_r1c1 .. i_a_r3c3
// output   | o_out_valid / i_out_ready   | o_inv_r1c1 .. o_inv_r3c3, o_determinant,
//          |                             | o_singular
// config   | i_cfg_we (no wait)          | i_cfg_data (det_epsilon)
//
// One matrix per cycle is taken while the pipe is not held (see below). Most of the
// depth is the divider: one quotient bit per stage over nine lanes, plus an overflow
// pre-check stage (a wide compare); each quotient-bit stage is one wide compare-and-subtract.
// Reset (synchronous, active low) clears all stage valid bits and loads det_epsilon
// with 66. When a result waits and i_out_ready is low, the whole pipe holds; bubbles
// are kept, nothing is lost or repeated.
module matrix3_inverse
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [EPS_WIDTH-1:0]         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_a_r1c1,
    input  logic signed [DATA_WIDTH-1:0] i_a_r1c2,
    input  logic signed [DATA_WIDTH-1:0] i_a_r1c3,
    input  logic signed [DATA_WIDTH-1:0] i_a_r2c1,
    input  logic signed [DATA_WIDTH-1:0] i_a_r2c2,
    input  logic signed [DATA_WIDTH-1:0] i_a_r2c3,
    input  logic signed [DATA_WIDTH-1:0] i_a_r3c1,
    input  logic signed [DATA_WIDTH-1:0] i_a_r3c2,
    input  logic signed [DATA_WIDTH-1:0] i_a_r3c3,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_inv_r1c1,
    output logic signed [DATA_WIDTH-1:0] o_inv_r1c2,
    output logic signed [DATA_WIDTH-1:0] o_inv_r1c3,
    output logic signed [DATA_WIDTH-1:0] o_inv_r2c1,
    output logic signed [DATA_WIDTH-1:0] o_inv_r2c2,
    output logic signed [DATA_WIDTH-1:0] o_inv_r2c3,
    output logic signed [DATA_WIDTH-1:0] o_inv_r3c1,
    output logic signed [DATA_WIDTH-1:0] o_inv_r3c2,
    output logic signed [DATA_WIDTH-1:0] o_inv_r3c3,
    output logic signed [DATA_WIDTH-1:0] o_determinant,
    output logic                         o_singular
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int CW   = 2 * W + 1;      // cofactor
    localparam int PW   = 2 * W + 1;      // split partial product
    localparam int TW   = 3 * W + 2;      // one determinant term
    localparam int DW   = 3 * W + 3;      // determinant
    localparam int RW   = (4 * W + 5 > 2 * W + 2 * F + 3) ? 4 * W + 5 : 2 * W + 2 * F + 3;
    localparam int NDIV = W + 2;          // pre-check + W+1 quotient bits

    localparam logic [W:0]   MAXP    = {2'b00, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MAXP_W  = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] MINN_W  = {1'b1, {(W - 1){1'b0}}};
    localparam logic [W-1:0] ONE_VAL = (F <= W - 2) ? (W'(1) << F) : MAXP_W;

    // Whole pipe advances together; stall only when the output register is full and i_out_ready is low
    logic w_adv;
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Threshold register
    logic [EPS_WIDTH-1:0] r_eps;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_data;
        end
    end

    logic signed [W-1:0] w_a [0:2][0:2];
    assign w_a[0][0] = i_a_r1c1;
    assign w_a[0][1] = i_a_r1c2;
    assign w_a[0][2] = i_a_r1c3;
    assign w_a[1][0] = i_a_r2c1;
    assign w_a[1][1] = i_a_r2c2;
    assign w_a[1][2] = i_a_r2c3;
    assign w_a[2][0] = i_a_r3c1;
    assign w_a[2][1] = i_a_r3c2;
    assign w_a[2][2] = i_a_r3c3;

    // Stage registers
    logic                  r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic signed [2*W-1:0] r_s1_p   [0:8][0:1];
    logic signed [W-1:0]   r_s1_row [0:2];
    logic signed [CW-1:0]  r_s2_c   [0:8];
    logic signed [W-1:0]   r_s2_row [0:2];
    logic signed [PW-1:0]  r_s3_lo  [0:2];
    logic signed [PW-1:0]  r_s3_hi  [0:2];
    logic signed [CW-1:0]  r_s3_c   [0:8];
    logic signed [TW-1:0]  r_s4_t   [0:2];
    logic signed [CW-1:0]  r_s4_c   [0:8];
    logic signed [DW-1:0]  r_s5_d;
    logic signed [CW-1:0]  r_s5_c   [0:8];

    // Divider stages, index 0 is the preparation stage
    logic                  r_v    [0:NDIV];
    logic [RW-1:0]         r_rem  [0:NDIV][0:8];
    logic [W:0]            r_q    [0:NDIV][0:8];
    logic                  r_ovf  [0:NDIV][0:8];
    logic                  r_neg  [0:NDIV][0:8];
    logic [RW-1:0]         r_dd   [0:NDIV];
    logic                  r_sing [0:NDIV];
    logic [W-1:0]          r_det  [0:NDIV];

    // Saturation stage and output register
    logic                  r_fv;
    logic [W-1:0]          r_fval [0:8];
    logic                  r_fovf [0:8];
    logic                  r_fsing;
    logic [W-1:0]          r_fdet;
    logic [W-1:0]          r_oinv [0:8];
    logic [W-1:0]          r_odet;
    logic                  r_osing;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_s5_v      <= 1'b0;
            r_v[0]      <= 1'b0;
            r_fv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_v      <= i_in_valid;
            r_s2_v      <= r_s1_v;
            r_s3_v      <= r_s2_v;
            r_s4_v      <= r_s3_v;
            r_s5_v      <= r_s4_v;
            r_v[0]      <= r_s5_v;
            r_fv        <= r_v[NDIV];
            o_out_valid <= r_fv;
        end
    end

    // Stages 1-2: cofactor products, then differences (adjugate, transposed indexing)
    genvar gi, gj, gk, gs, gn;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_ci
            for (gj = 0; gj < 3; gj++) begin : g_cj
                always_ff @(posedge i_clk) begin
                    if (w_adv) begin
                        r_s1_p[gi*3+gj][0] <= w_a[(gj+1)%3][(gi+1)%3] * w_a[(gj+2)%3][(gi+2)%3];
                        r_s1_p[gi*3+gj][1] <= w_a[(gj+1)%3][(gi+2)%3] * w_a[(gj+2)%3][(gi+1)%3];
                        r_s2_c[gi*3+gj]    <= CW'(r_s1_p[gi*3+gj][0]) - CW'(r_s1_p[gi*3+gj][1]);
                        r_s3_c[gi*3+gj]    <= r_s2_c[gi*3+gj];
                        r_s4_c[gi*3+gj]    <= r_s3_c[gi*3+gj];
                        r_s5_c[gi*3+gj]    <= r_s4_c[gi*3+gj];
                    end
                end
            end
        end

        // Stages 3-4: row 1 times first adjugate column, cofactor split into a low W-bit part and a high part
        for (gk = 0; gk < 3; gk++) begin : g_det
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_s1_row[gk] <= w_a[0][gk];
                    r_s2_row[gk] <= r_s1_row[gk];
                    r_s3_lo[gk]  <= r_s2_row[gk] * $signed({1'b0, r_s2_c[gk*3][W-1:0]});
                    r_s3_hi[gk]  <= r_s2_row[gk] * $signed(r_s2_c[gk*3][CW-1:W]);
                    r_s4_t[gk]   <= (TW'(r_s3_hi[gk]) <<< W) + TW'(r_s3_lo[gk]);
                end
            end
        end
    endgenerate

    // Stage 5: determinant sum
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_d <= DW'(r_s4_t[0]) + DW'(r_s4_t[1]) + DW'(r_s4_t[2]);
        end
    end

    // Stage 6: magnitudes, threshold, rounded determinant, dividends
    logic [DW-1:0] w_dabs;
    logic          w_dneg;
    logic [RW-1:0] w_drnd;
    logic [W-1:0]  w_det;

    always_comb begin
        w_dneg = r_s5_d[DW-1];
        w_dabs = w_dneg ? DW'(-r_s5_d) : DW'(r_s5_d);
        w_drnd = (RW'(w_dabs) + (RW'(1) << (2 * F - 1))) >> (2 * F);
        if (w_drnd > RW'(MAXP + (W + 1)'(w_dneg))) begin
            w_det = w_dneg ? MINN_W : MAXP_W;
        end else begin
            w_det = w_dneg ? W'(RW'(0) - w_drnd) : w_drnd[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dd[0]   <= RW'(w_dabs) << 1;
            r_sing[0] <= RW'(w_dabs) <= (RW'(r_eps) << (2 * F));
            r_det[0]  <= w_det;
        end
    end

    generate
        for (gn = 0; gn < 9; gn++) begin : g_prep
            logic [CW-1:0] w_cabs;
            assign w_cabs = r_s5_c[gn][CW-1] ? CW'(-r_s5_c[gn]) : CW'(r_s5_c[gn]);
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    // round(C*2^2F / D) = floor((2|C|*2^2F + |D|) / 2|D|)
                    r_rem[0][gn] <= (RW'(w_cabs) << (2 * F + 1)) + RW'(w_dabs);
                    r_q[0][gn]   <= '0;
                    r_ovf[0][gn] <= 1'b0;
                    r_neg[0][gn] <= r_s5_c[gn][CW-1] ^ w_dneg;
                end
            end
        end

        // Restoring divider: pre-check for quotient >= 2^(W+1), then one bit per stage
        for (gs = 1; gs <= NDIV; gs++) begin : g_div
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gs] <= 1'b0;
                end else if (w_adv) begin
                    r_v[gs] <= r_v[gs-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dd[gs]   <= r_dd[gs-1];
                    r_sing[gs] <= r_sing[gs-1];
                    r_det[gs]  <= r_det[gs-1];
                end
            end
            for (gn = 0; gn < 9; gn++) begin : g_lane
                if (gs == 1) begin : g_pre
                    always_ff @(posedge i_clk) begin
                        if (w_adv) begin
                            r_rem[gs][gn] <= r_rem[gs-1][gn];
                            r_q[gs][gn]   <= r_q[gs-1][gn];
                            r_ovf[gs][gn] <= r_rem[gs-1][gn] >= (r_dd[gs-1] << (W + 1));
                            r_neg[gs][gn] <= r_neg[gs-1][gn];
                        end
                    end
                end else begin : g_bit
                    localparam int K = NDIV - gs;
                    logic [RW:0] w_diff;
                    assign w_diff = {1'b0, r_rem[gs-1][gn]} - {1'b0, r_dd[gs-1] << K};
                    always_ff @(posedge i_clk) begin
                        if (w_adv) begin
                            if (!w_diff[RW]) begin
                                r_rem[gs][gn] <= w_diff[RW-1:0];
                                r_q[gs][gn]   <= r_q[gs-1][gn] | ((W + 1)'(1) << K);
                            end else begin
                                r_rem[gs][gn] <= r_rem[gs-1][gn];
                                r_q[gs][gn]   <= r_q[gs-1][gn];
                            end
                            r_ovf[gs][gn] <= r_ovf[gs-1][gn];
                            r_neg[gs][gn] <= r_neg[gs-1][gn];
                        end
                    end
                end
            end
        end

        // Saturation check, then identity substitution into the output register
        for (gn = 0; gn < 9; gn++) begin : g_sat
            logic [W:0] w_q;
            logic       w_ng;
            assign w_q  = r_q[NDIV][gn];
            assign w_ng = r_neg[NDIV][gn];
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_fovf[gn] <= r_ovf[NDIV][gn] || (w_q > MAXP + (W + 1)'(w_ng));
                    r_fval[gn] <= w_ng ? W'((W + 1)'(0) - w_q) : w_q[W-1:0];
                end
            end
        end
    endgenerate

    logic w_bad;
    always_comb begin
        w_bad = r_fsing;
        for (int n = 0; n < 9; n++) begin
            w_bad = w_bad | r_fovf[n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fsing <= r_sing[NDIV];
            r_fdet  <= r_det[NDIV];
            for (int n = 0; n < 9; n++) begin
                if (w_bad) begin
                    r_oinv[n] <= (n % 4 == 0) ? ONE_VAL : '0;
                end else begin
                    r_oinv[n] <= r_fval[n];
                end
            end
            r_odet  <= r_fdet;
            r_osing <= w_bad;
        end
    end

    assign o_inv_r1c1    = r_oinv[0];
    assign o_inv_r1c2    = r_oinv[1];
    assign o_inv_r1c3    = r_oinv[2];
    assign o_inv_r2c1    = r_oinv[3];
    assign o_inv_r2c2    = r_oinv[4];
    assign o_inv_r2c3    = r_oinv[5];
    assign o_inv_r3c1    = r_oinv[6];
    assign o_inv_r3c2    = r_oinv[7];
    assign o_inv_r3c3    = r_oinv[8];
    assign o_determinant = r_odet;
    assign o_singular    = r_osing;

endmodule

// ===== tb/sv/matrix3_inverse_tb.sv =====
`timescale 1ns / 1ps

module matrix3_inverse_tb
    import m3inv_pkg::*;
();

    localparam int  LATENCY = DATA_WIDTH_DEF + 10;
    localparam logic [31:0] ONE_Q = 32'h0001_0000;
    localparam logic [31:0] MAXP  = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN  = 32'h8000_0000;

    // nine elements row by row, element 0 in the low bits
    typedef logic [8:0][31:0] t_mat;
    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        t_mat        inv;
        logic [31:0] det;
        logic        sing;
    } t_inv_result;

    typedef struct packed {
        t_mat        a;
        logic        typed;
        t_inv_result res;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [EPS_WIDTH-1:0]  i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_mat                  a_bus = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_mat                  inv_bus;
    logic signed [31:0]    o_determinant;
    logic                  o_singular;

    logic [EPS_WIDTH-1:0]  eps_shadow = EPS_RESET;
    t_inv_result           pending_inverses[$];
    int                    error_count = 0;
    int                    transfers_in = 0;
    int                    transfers_out = 0;
    int                    singular_seen = 0;

    always #2 i_clk = ~i_clk;

    matrix3_inverse DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_a_r1c1(a_bus[0]), .i_a_r1c2(a_bus[1]), .i_a_r1c3(a_bus[2]),
        .i_a_r2c1(a_bus[3]), .i_a_r2c2(a_bus[4]), .i_a_r2c3(a_bus[5]),
        .i_a_r3c1(a_bus[6]), .i_a_r3c2(a_bus[7]), .i_a_r3c3(a_bus[8]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_inv_r1c1(inv_bus[0]), .o_inv_r1c2(inv_bus[1]), .o_inv_r1c3(inv_bus[2]),
        .o_inv_r2c1(inv_bus[3]), .o_inv_r2c2(inv_bus[4]), .o_inv_r2c3(inv_bus[5]),
        .o_inv_r3c1(inv_bus[6]), .o_inv_r3c2(inv_bus[7]), .o_inv_r3c3(inv_bus[8]),
        .o_determinant(o_determinant), .o_singular(o_singular)
    );

    // Round n/d to nearest (ties away from zero), then clamp to 32 bits.
    function automatic logic [31:0] round_clamp(t_wide n, t_wide d, inout bit clipped);
        logic        neg;
        logic [255:0] an, ad, mag;
        neg = (n < 0) != (d < 0);
        an  = (n < 0) ? -n : n;
        ad  = (d < 0) ? -d : d;
        mag = (2 * an + ad) / (2 * ad);
        if (neg) begin
            if (mag > 256'h8000_0000) begin
                clipped = 1'b1;
                return MINN;
            end
            return -mag[31:0];
        end
        if (mag > 256'h7FFF_FFFF) begin
            clipped = 1'b1;
            return MAXP;
        end
        return mag[31:0];
    endfunction

    // Adjugate inverse with exact cofactors and determinant.
    function automatic t_inv_result invert3(t_mat m, logic [EPS_WIDTH-1:0] eps);
        t_wide       a [3][3];
        t_wide       cof [3][3];
        t_wide       det, det_abs, thr;
        bit          clipped, dummy;
        t_inv_result r;
        clipped = 1'b0;
        dummy   = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = $signed(m[i*3+j]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = a[(j+1)%3][(i+1)%3] * a[(j+2)%3][(i+2)%3]
                          - a[(j+1)%3][(i+2)%3] * a[(j+2)%3][(i+1)%3];
        det = 0;
        for (int k = 0; k < 3; k++)
            det += a[0][k] * cof[k][0];
        r.det   = round_clamp(det, t_wide'(1) <<< 32, dummy);
        det_abs = (det < 0) ? -det : det;
        thr     = t_wide'(eps) <<< 32;
        r.sing  = det_abs <= thr;
        r.inv   = '0;
        if (!r.sing)
            for (int i = 0; i < 9; i++)
                r.inv[i] = round_clamp(cof[i/3][i%3] <<< 32, det, clipped);
        if (r.sing || clipped) begin
            r.sing = 1'b1;
            r.inv  = '0;
            r.inv[0] = ONE_Q;
            r.inv[4] = ONE_Q;
            r.inv[8] = ONE_Q;
        end
        return r;
    endfunction

    function automatic t_mat diag3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_mat m;
        m = '0;
        m[0] = x;
        m[4] = y;
        m[8] = z;
        return m;
    endfunction

    function automatic t_mat fill3(logic [31:0] v);
        t_mat m;
        for (int i = 0; i < 9; i++) m[i] = v;
        return m;
    endfunction

    function automatic t_inv_result typed_res(t_mat inv, logic [31:0] det, logic sing);
        t_inv_result r;
        r.inv  = inv;
        r.det  = det;
        r.sing = sing;
        return r;
    endfunction

    function automatic logic [31:0] sym_rand(int unsigned span);
        logic [31:0] v;
        v = $urandom_range(span, 0);
        return $urandom_range(1, 0) ? -v : v;
    endfunction

    // Random matrix: most often well-conditioned, the rest raw bits, small values,
    // near-singular and rank-deficient shapes.
    function automatic t_mat rand_matrix();
        t_mat        m;
        int unsigned kind;
        logic [31:0] s;
        kind = $urandom_range(9, 0);
        for (int i = 0; i < 9; i++) m[i] = $urandom();
        case (kind)
            0, 1: ;
            2, 3, 4, 5: begin
                for (int i = 0; i < 9; i++) m[i] = sym_rand(32'h4000);
                m[0] = sym_rand(32'h40000) | 32'h8000;
                m[4] = sym_rand(32'h40000) | 32'h8000;
                m[8] = sym_rand(32'h40000) | 32'h8000;
            end
            6, 7: begin
                for (int i = 0; i < 9; i++) m[i] = sym_rand(32'h30000);
            end
            8: begin
                for (int i = 0; i < 9; i++) m[i] = sym_rand(32'h20000);
                for (int j = 0; j < 3; j++) m[6+j] = m[j] + sym_rand(4);
            end
            default: begin
                for (int i = 0; i < 6; i++) m[i] = sym_rand(32'h10000);
                s = $urandom_range(3, 0);
                for (int j = 0; j < 3; j++) m[6+j] = m[j] <<< s;
            end
        endcase
        return m;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h (transfer %0d)", what, got, want,
                 transfers_out);
        error_count++;
    endtask

    // Receiver: stall pattern switches at random between modes; compare each transfer
    // against the oldest pending inverse.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    always @(posedge i_clk) begin
        t_inv_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_inverses.size() == 0) begin
                report("unexpected result transfer", o_determinant, 32'h0);
            end else begin
                want = pending_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (inv_bus[i] !== want.inv[i])
                        report($sformatf("inv_r%0dc%0d", i/3+1, i%3+1), inv_bus[i],
                               want.inv[i]);
                if (o_determinant !== want.det)
                    report("determinant", o_determinant, want.det);
                if (o_singular !== want.sing)
                    report("singular", 32'(o_singular), 32'(want.sing));
                if (want.sing) singular_seen++;
            end
            transfers_out++;
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(3, 0);
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= $urandom_range(1, 0);
            2: i_out_ready <= ($urandom_range(3, 0) == 0);
            default: i_out_ready <= (rx_cycle % 5 != 0);
        endcase
    end

    // Sender burst state
    int unsigned burst_left = 0;

    // Present one matrix and hold it until the transfer; gaps fall between bursts.
    task automatic send_matrix(t_mat m, logic typed, t_inv_result typed_exp);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(7, 0) == 0) ? 120 : $urandom_range(30, 1);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        a_bus      <= m;
        do @(posedge i_clk); while (!o_in_ready);
        pending_inverses.push_back(typed ? typed_exp : invert3(m, eps_shadow));
        transfers_in++;
    endtask

    // Drain the pipe, then let it settle before a register write.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_inverses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [EPS_WIDTH-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        eps_shadow = v;
    endtask

    t_stim_row                 directed[$];
    logic [EPS_WIDTH-1:0]      eps_plan[6];
    t_mat                      id_q, neg_id_q, m;
    t_inv_result               none;

    initial begin
        none     = '0;
        id_q     = diag3(ONE_Q, ONE_Q, ONE_Q);
        neg_id_q = diag3(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);

        // Rows with a typed result: identity, zero, rank-one extremes, minus identity.
        directed.push_back({id_q, 1'b1, typed_res(id_q, ONE_Q, 1'b0)});
        directed.push_back({fill3(32'h0), 1'b1, typed_res(id_q, 32'h0, 1'b1)});
        directed.push_back({fill3(MAXP), 1'b1, typed_res(id_q, 32'h0, 1'b1)});
        directed.push_back({fill3(MINN), 1'b1, typed_res(id_q, 32'h0, 1'b1)});
        directed.push_back({neg_id_q, 1'b1, typed_res(neg_id_q, 32'hFFFF_0000, 1'b0)});
        // Rows left to the predictor.
        directed.push_back({diag3(32'h2_0000, 32'h2_0000, 32'h2_0000), 1'b0, none});
        directed.push_back({diag3(MAXP, MAXP, 32'd2), 1'b0, none});     // inverse clips
        directed.push_back({diag3(MAXP, MAXP, MAXP), 1'b0, none});      // det clips
        directed.push_back({diag3(MINN, MINN, MINN), 1'b0, none});
        directed.push_back({diag3(32'd1, 32'd1, 32'd1), 1'b0, none});  // tiny det
        directed.push_back({diag3(ONE_Q, ONE_Q, 32'd66), 1'b0, none}); // det on threshold
        directed.push_back({diag3(ONE_Q, ONE_Q, 32'd67), 1'b0, none}); // just above it
        directed.push_back({diag3(ONE_Q, ONE_Q, 32'hFFFF_0000), 1'b0, none});
        m = '0; m[1] = ONE_Q; m[5] = ONE_Q; m[6] = ONE_Q;                 // permutation
        directed.push_back({m, 1'b0, none});
        for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA;
        directed.push_back({m, 1'b0, none});
        m = id_q; m[1] = 32'h3_0000; m[2] = 32'hFFFE_8000; m[5] = 32'h0000_4000;
        directed.push_back({m, 1'b0, none});                               // triangular
        for (int i = 0; i < 4; i++) directed.push_back({rand_matrix(), 1'b0, none});

        eps_plan[0] = EPS_RESET;
        eps_plan[1] = '0;
        eps_plan[2] = '1;
        eps_plan[3] = EPS_WIDTH'(32'h1_0000);
        eps_plan[4] = EPS_WIDTH'($urandom_range(32'h2000, 1));
        eps_plan[5] = EPS_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run at the reset threshold.
        foreach (directed[k])
            send_matrix(directed[k].a, directed[k].typed, directed[k].res);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) write_eps(eps_plan[ph]);
            for (int n = 0; n < 90; n++) begin
                // in the second phase only, hold off once mid-phase until the pipe is empty
                if (ph == 1 && n == 45) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending_inverses.size() != 0);
                end
                send_matrix(rand_matrix(), 1'b0, none);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_inverses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Covered %0d matrices in, %0d results out, %0d flagged singular,",
                 transfers_in, transfers_out, singular_seen);
        $display("over six threshold settings including zero and full scale.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Timeout with %0d results still pending", pending_inverses.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/m3inv_pkg.sv
hdl/matrix3_inverse.sv
tb/sv/matrix3_inverse_tb.sv
